@@ rtl/core/sactc_pkg.sv @@
// ----------------------------------------------------------------------------
// sactc_pkg
// Shared types and constants of the set-associative cache tag controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sactc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ASSOC   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 2'd3;

    // replacement policy codes
    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_RAND = 2'd1;
    localparam logic [1:0] POL_TREE = 2'd2;

    // associativity codes
    localparam logic [1:0] ASSOC_DIRECT = 2'd0;
    localparam logic [1:0] ASSOC_FOUR   = 2'd1;
    localparam logic [1:0] ASSOC_EIGHT  = 2'd2;

    localparam logic [1:0] RST_REPLACE = POL_LRU;
    localparam logic [1:0] RST_WRITE   = 2'd0;
    localparam logic [1:0] RST_ASSOC   = ASSOC_EIGHT;
    localparam logic [3:0] RST_OFFSET  = 4'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic clear_en;
        logic issue;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/set_assoc_cache_tag_controller.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Set-associative cache tag controller with LRU, tree pseudo-LRU and random
// replacement, write-back/write-through and allocate/around write policies.
// ----------------------------------------------------------------------------
// On accept the indexed set's row is read into registers from the eight
// banked tag/dirty/recency memories, together with its fill count and tree
// bits; the evaluation state then searches the ways, picks a victim and
// writes the row back once the result register can take the result. One
// access is in flight at a time; the result register lets a new word be
// accepted while the previous result is still waiting. After reset a
// clearing pass runs before the first word is accepted; configuration
// writes are taken at any time.
`default_nettype none

module set_assoc_cache_tag_controller #(
    parameter int LINES     = 1024,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [63:0]                      s_tdata,   // address
    input  wire logic [0:0]                       s_tuser,   // kind
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,   // hit, evict_dirty, zero pad
    input  wire logic                             cfg_wr_en,
    input  wire logic [sactc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sactc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    sactc_pkg::cmd_t    cmd;
    sactc_pkg::status_t status;
    logic               hit, evict;

    sactc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    sactc_datapath #(
        .LINES     (LINES),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_kind    (s_tuser[0]),
        .s_addr    (s_tdata),
        .m_tready  (m_tready),
        .m_valid   (m_tvalid),
        .m_hit     (hit),
        .m_evict   (evict)
    );

    assign m_tdata = {6'd0, evict, hit};

    // one word in flight: no accept in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while previous lookup in flight");

    // a commit never overwrites a result not yet taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("result overwritten before it was taken");

    // a commit always presents a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("commit without result");

endmodule

`default_nettype wire

@@ rtl/core/sactc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sactc_ctrl
// Sequencer: clearing pass after reset, then lookup and write-back per word.
// ----------------------------------------------------------------------------
`default_nettype none

module sactc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              m_tready,
    input  sactc_pkg::status_t     status,
    output logic                   s_tready,
    output sactc_pkg::cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.issue  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // wait until the output register can take the result
                if (!status.out_full || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/sactc_datapath.sv @@
// ----------------------------------------------------------------------------
// sactc_datapath
// Banked tag, dirty and recency memories, fill counts, tree bits, LFSR,
// hit search, victim choice and write-back, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sactc_datapath #(
    parameter int LINES     = 1024,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  sactc_pkg::cmd_t                       cmd,
    output sactc_pkg::status_t                    status,
    input  wire logic                             cfg_wr_en,
    input  wire logic [sactc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sactc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                             s_kind,
    input  wire logic [63:0]                      s_addr,
    input  wire logic                             m_tready,
    output logic                                  m_valid,
    output logic                                  m_hit,
    output logic                                  m_evict
);

    localparam int LOG   = $clog2(LINES + 1) - 1;
    localparam int RW    = (LOG > 3) ? LOG - 3 : 1;
    localparam int ROWS  = 1 << (LOG - 3);
    localparam int TW    = LOG - 1;
    localparam int TROWS = 1 << TW;
    localparam int FILLS = 1 << LOG;
    localparam logic [1:0] MWB = (MAX_WAYS >= 8) ? 2'd3 :
                                 (MAX_WAYS >= 4) ? 2'd2 :
                                 (MAX_WAYS >= 2) ? 2'd1 : 2'd0;
    localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDR_BITS);

    // configuration
    logic [1:0] replace_reg, write_reg, assoc_reg;
    logic [3:0] offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replace_reg <= sactc_pkg::RST_REPLACE;
            write_reg   <= sactc_pkg::RST_WRITE;
            assoc_reg   <= sactc_pkg::RST_ASSOC;
            offset_reg  <= sactc_pkg::RST_OFFSET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sactc_pkg::REG_REPLACE: replace_reg <= cfg_wdata[1:0];
                sactc_pkg::REG_WRITE:   write_reg   <= cfg_wdata[1:0];
                sactc_pkg::REG_ASSOC:   assoc_reg   <= cfg_wdata[1:0];
                sactc_pkg::REG_OFFSET:  offset_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [1:0] wb_mode, wb, pol;
    logic [3:0] ways;
    logic [2:0] wm;
    logic       wback, around;

    always_comb begin
        wb_mode = (assoc_reg == sactc_pkg::ASSOC_DIRECT) ? 2'd0 :
                  (assoc_reg == sactc_pkg::ASSOC_FOUR)   ? 2'd2 : 2'd3;
        wb      = (wb_mode > MWB) ? MWB : wb_mode;
        ways    = 4'd1 << wb;
        wm      = 3'(ways - 4'd1);
        pol     = (replace_reg == sactc_pkg::POL_RAND ||
                   replace_reg == sactc_pkg::POL_TREE) ? replace_reg : sactc_pkg::POL_LRU;
        wback   = !write_reg[0];
        around  = write_reg[1];
    end

    // address split at issue
    logic [63:0]          addr_m;
    logic [4:0]           ib;
    logic [LOG-1:0]       set_mask, set_i, line_i;
    logic [5:0]           tsh;
    logic [ADDR_BITS-1:0] tag_i;
    logic [RW-1:0]        rrow;

    always_comb begin
        addr_m   = s_addr & AMASK;
        ib       = 5'(LOG) - 5'(wb);
        set_mask = {LOG{1'b1}} >> wb;
        set_i    = LOG'(addr_m >> offset_reg) & set_mask;
        line_i   = set_i << wb;
        tsh      = 6'(offset_reg) + 6'(ib);
        tag_i    = ADDR_BITS'(addr_m >> tsh);
        rrow     = RW'(line_i >> 3);
    end

    logic                 kind_reg;
    logic [LOG-1:0]       set_reg, line_reg;
    logic [ADDR_BITS-1:0] tag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            kind_reg <= s_kind;
            set_reg  <= set_i;
            line_reg <= line_i;
            tag_reg  <= tag_i;
        end
    end

    // clearing pass
    logic [LOG-1:0] clear_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
        end else if (cmd.clear_en) begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // memories
    logic [ADDR_BITS-1:0] tag_rd   [8];
    logic                 dirty_rd [8];
    logic [2:0]           stack_rd [8];
    logic [3:0]           fill_rd;
    logic [6:0]           tree_rd;

    logic [7:0]      tag_we, dirty_we, stack_we;
    logic            dirty_val;
    logic [7:0][2:0] stack_wbank;
    logic            fill_we, tree_we;
    logic [3:0]      fill_wdata;
    logic [6:0]      tree_wdata;

    logic [RW-1:0] wrow, crow;
    assign wrow = RW'(line_reg >> 3);
    assign crow = RW'(clear_cnt_reg);

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [ADDR_BITS-1:0] tag_mem   [ROWS];
        logic                 dirty_mem [ROWS];
        logic [2:0]           stack_mem [ROWS];

        always_ff @(posedge aclk) begin
            if (cmd.commit && tag_we[b]) tag_mem[wrow] <= tag_reg;
            if (cmd.issue) tag_rd[b] <= tag_mem[rrow];
        end

        always_ff @(posedge aclk) begin
            if (cmd.clear_en) begin
                dirty_mem[crow] <= 1'b0;
            end else if (cmd.commit && dirty_we[b]) begin
                dirty_mem[wrow] <= dirty_val;
            end
            if (cmd.issue) dirty_rd[b] <= dirty_mem[rrow];
        end

        always_ff @(posedge aclk) begin
            if (cmd.clear_en) begin
                stack_mem[crow] <= 3'd0;
            end else if (cmd.commit && stack_we[b]) begin
                stack_mem[wrow] <= stack_wbank[b];
            end
            if (cmd.issue) stack_rd[b] <= stack_mem[rrow];
        end
    end

    logic [3:0] fill_mem [FILLS];
    logic [6:0] tree_mem [TROWS];

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            fill_mem[clear_cnt_reg] <= 4'd0;
        end else if (cmd.commit && fill_we) begin
            fill_mem[set_reg] <= fill_wdata;
        end
        if (cmd.issue) fill_rd <= fill_mem[set_i];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            tree_mem[TW'(clear_cnt_reg)] <= 7'd0;
        end else if (cmd.commit && tree_we) begin
            tree_mem[TW'(set_reg)] <= tree_wdata;
        end
        if (cmd.issue) tree_rd <= tree_mem[TW'(set_i)];
    end

    // replacement helpers
    function automatic logic [7:0][2:0] stack_touch(
        input logic [7:0][2:0] st,
        input logic [2:0]      msk,
        input logic [3:0]      nw,
        input logic [2:0]      id,
        input logic            search
    );
        logic [7:0][2:0] r;
        logic [2:0]      p;
        p = 3'd0;
        r = st;
        if (search) begin
            for (int i = 0; i < 8; i++) begin
                if (4'(i) < nw && (st[i] & msk) == id) p = 3'(i);
            end
        end
        for (int i = 0; i < 7; i++) begin
            if (3'(i) >= p && 4'(i + 1) < nw) r[i] = st[i + 1];
        end
        for (int i = 0; i < 8; i++) begin
            if (4'(i) == nw - 4'd1) r[i] = id;
        end
        return r;
    endfunction

    function automatic logic [6:0] tree_touch(
        input logic [6:0] t,
        input logic [1:0] w,
        input logic [2:0] id
    );
        logic [6:0] r;
        logic [3:0] pos;
        logic       b;
        r   = t;
        pos = 4'd1;
        for (int s = 0; s < 3; s++) begin
            if (2'(s) < w) begin
                b = id[2'(w - 2'd1 - 2'(s))];
                r[3'(pos - 4'd1)] = !b;
                pos = {pos[2:0], b};
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] tree_victim(
        input logic [6:0] t,
        input logic [1:0] w
    );
        logic [3:0] pos;
        logic [2:0] v;
        logic       b;
        pos = 4'd1;
        v   = 3'd0;
        for (int s = 0; s < 3; s++) begin
            if (2'(s) < w) begin
                b   = t[3'(pos - 4'd1)];
                pos = {pos[2:0], b};
                v   = {v[1:0], b};
            end
        end
        return v;
    endfunction

    // lookup and update
    logic [15:0]          lfsr_reg, lfsr_next;
    logic                 lfsr_adv;
    logic [2:0]           base_lo, way, hway, bank, vic;
    logic [ADDR_BITS-1:0] tw [8];
    logic [7:0]           dw;
    logic [7:0][2:0]      sw, stack_new;
    logic [3:0]           n;
    logic                 hit, evict, alloc, stack_upd;

    always_comb begin
        base_lo = line_reg[2:0];
        for (int i = 0; i < 8; i++) begin
            bank  = base_lo + 3'(i);
            tw[i] = tag_rd[bank];
            dw[i] = dirty_rd[bank];
            sw[i] = stack_rd[bank];
        end
        n = (fill_rd > ways) ? ways : fill_rd;

        hit  = 1'b0;
        hway = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (4'(i) < n && tw[i] == tag_reg) begin
                hit  = 1'b1;
                hway = 3'(i);
            end
        end

        lfsr_next  = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                      lfsr_reg[15:1]};
        vic        = tree_victim(tree_rd, wb);
        way        = 3'd0;
        evict      = 1'b0;
        alloc      = 1'b0;
        lfsr_adv   = 1'b0;
        stack_upd  = 1'b0;
        stack_new  = sw;
        tree_we    = 1'b0;
        tree_wdata = tree_rd;
        fill_we    = 1'b0;
        fill_wdata = n + 4'd1;
        dirty_val  = 1'b0;

        priority if (hit) begin
            way        = hway;
            stack_upd  = (pol == sactc_pkg::POL_LRU);
            stack_new  = stack_touch(sw, wm, ways, hway, 1'b1);
            tree_we    = (pol == sactc_pkg::POL_TREE) && (wb != 2'd0);
            tree_wdata = tree_touch(tree_rd, wb, hway);
            dirty_val  = 1'b1;
        end else if (kind_reg == sactc_pkg::KIND_WRITE && around) begin
            // write miss without allocation
        end else if (n < ways) begin
            alloc      = 1'b1;
            way        = n[2:0];
            stack_upd  = (pol == sactc_pkg::POL_LRU);
            stack_new  = stack_touch(sw, wm, ways, n[2:0], 1'b0);
            tree_we    = (pol == sactc_pkg::POL_TREE) && (wb != 2'd0);
            tree_wdata = tree_touch(tree_rd, wb, n[2:0]);
            fill_we    = 1'b1;
        end else begin
            alloc = 1'b1;
            priority if (pol == sactc_pkg::POL_RAND) begin
                lfsr_adv = 1'b1;
                way      = lfsr_next[2:0] & wm;
            end else if (pol == sactc_pkg::POL_TREE) begin
                way        = vic;
                tree_we    = (wb != 2'd0);
                tree_wdata = tree_touch(tree_rd, wb, vic);
            end else begin
                way       = sw[0] & wm;
                stack_upd = 1'b1;
                stack_new = stack_touch(sw, wm, ways, sw[0] & wm, 1'b1);
            end
            evict = dw[way];
        end

        for (int b = 0; b < 8; b++) begin
            tag_we[b]      = alloc && (3'(b) == base_lo + way);
            dirty_we[b]    = (3'(b) == base_lo + way) &&
                             (alloc || (hit && kind_reg == sactc_pkg::KIND_WRITE && wback));
            stack_we[b]    = stack_upd && ({1'b0, 3'(b) - base_lo} < ways);
            stack_wbank[b] = stack_new[3'(b) - base_lo];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= sactc_pkg::LFSR_SEED;
        end else if (cmd.commit && lfsr_adv) begin
            lfsr_reg <= lfsr_next;
        end
    end

    // result register
    logic m_valid_reg, hit_reg, evict_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg   <= hit;
            evict_reg <= evict;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = hit_reg;
    assign m_evict = evict_reg;

    assign status.clear_last = (clear_cnt_reg == {LOG{1'b1}});
    assign status.out_full   = m_valid_reg;

endmodule

`default_nettype wire
